FILE: rtl/core/fma_pkg.sv
`default_nettype none

package fma_pkg;

  localparam int AGENT_W    = 4;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 5;

  localparam logic REQ_LOCK    = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [AGENT_W-1:0] requester;
  } fma_in_t;

  typedef struct packed {
    logic                 grant_valid;
    logic [AGENT_W-1:0]   granted_id;
    logic [STATUS_W-1:0]  status;
    logic                 lock_busy;
    logic [AGENT_W-1:0]   holder_now;
    logic [CNT_OUT_W-1:0] waiting_count;
  } fma_out_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } fma_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/fma_ram.sv
`default_nettype none

module fma_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/fma_ctrl.sv
`default_nettype none

module fma_ctrl
  import fma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output fma_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.commit  = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fma_dp.sv
`default_nettype none

module fma_dp
  import fma_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire fma_cmd_t cmd,
  input  wire fma_in_t  in_data,
  output fma_out_t      out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fma_in_t          item_r;
  fma_out_t         out_r, out_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt, count_mid;
  logic             busy_r, busy_nxt, busy_mid;
  logic [AGENT_W-1:0] holder_r, holder_nxt;
  logic [AGENT_W-1:0] rd_data, head_id;
  logic             is_req, full, enq, rel_ok, grant;
  logic [STATUS_W-1:0] status;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  fma_ram #(
    .WIDTH (AGENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && enq),
    .wr_addr (tail_r),
    .wr_data (item_r.requester),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  always_comb begin
    is_req    = (item_r.req_type == REQ_LOCK);
    full      = (count_r == CW'(QUEUE_DEPTH));
    enq       = is_req && !full;
    rel_ok    = !is_req && busy_r && (holder_r == item_r.requester);
    if (is_req) begin
      status = full ? ST_QUEUE_FULL : ST_OK;
    end else begin
      status = rel_ok ? ST_OK : ST_NOT_HOLDER;
    end
    busy_mid  = busy_r && !rel_ok;
    count_mid = count_r + CW'(enq);
    grant     = !busy_mid && (count_mid != '0);
    // bypass the store when the queue was empty
    head_id   = (count_r == '0) ? item_r.requester : rd_data;

    count_nxt  = count_mid - CW'(grant);
    busy_nxt   = busy_mid || grant;
    holder_nxt = grant ? head_id : holder_r;
    head_nxt   = grant ? ptr_inc(head_r) : head_r;
    tail_nxt   = enq ? ptr_inc(tail_r) : tail_r;

    out_nxt.grant_valid   = grant;
    out_nxt.granted_id    = grant ? head_id : '0;
    out_nxt.status        = status;
    out_nxt.lock_busy     = busy_nxt;
    out_nxt.holder_now    = busy_nxt ? holder_nxt : '0;
    out_nxt.waiting_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      busy_r   <= 1'b0;
      holder_r <= '0;
    end else if (cmd.commit) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      busy_r   <= busy_nxt;
      holder_r <= holder_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: rtl/core/fifo_mutex_arbiter_top.sv
// First-come first-served lock manager for one shared resource.
// Input channel (in_valid / in_stall / in_data): each request either asks
// for the lock (appended to the waiting queue) or releases it (honoured only
// from the current holder). Output channel (out_valid / out_stall /
// out_data): exactly one result per request, in order, giving any grant
// made, a status code, the lock state and the number of agents waiting.
// A request taken is registered first; its result is then registered into the
// output register once that register is free. No new request is taken while
// one is in progress, as the queue store has a registered read port, which
// reads the queue head in the cycle the request is taken.
// A new request is taken while the previous result still waits in the output
// register; if the receiver keeps stalling, the next result is held back and
// in_stall stays high until the output register drains.
// Reset: lock free, queue empty, no result pending. The queue store needs no
// clearing pass; requests are taken from the first cycle after reset.
// A request at a full queue is dropped with status queue-full.
`default_nettype none

module fifo_mutex_arbiter_top
  import fma_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire fma_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output fma_out_t     out_data
);

  fma_cmd_t cmd;

  fma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  fma_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
